### sv/depth_pixel_backprojection_top_assert.svh
// Assertion macros for the depth back-projection top level.
// Included by depth_pixel_backprojection_top.sv; empty when SYNTH is defined.
`ifndef DEPTH_PIXEL_BACKPROJECTION_TOP_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_TOP_ASSERT_SVH
`ifndef SYNTH
`define DPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpb assertion failed");
`define DPB_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("dpb latency assertion failed");
`else
`define DPB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DPB_ASSERT_DLY(label, clk, rst_n, ante, n, cons)
`endif
`endif

### sv/dpb_pkg.sv
// Shared types and fixed-point constants for depth back-projection.
// No dependencies.
`default_nettype none
package dpb_pkg;
	localparam int CFG_W = 24;

	typedef enum logic [1:0] {
		REG_FOCAL_X_INV,
		REG_FOCAL_Y_INV,
		REG_CENTER_X,
		REG_CENTER_Y
	} cfg_reg_t;

	localparam logic [23:0] FOCAL_INV_RST = 24'd16777;
	localparam logic [15:0] CENTER_X_RST = 16'd15360;
	localparam logic [15:0] CENTER_Y_RST = 16'd8640;

	// z: floor((d*65536 + 500)/1000) = floor((d*8192 + 62)/125)
	localparam logic [28:0] Z_BIAS = 29'd62;
	localparam logic [29:0] Z_REC125 = 30'd549755814; // ceil(2^36/125)

	// lateral: divide by 4096000 = 2^15 * 125, rounded half up
	localparam logic [56:0] LAT_HALF = 57'd2048000;
	localparam logic [41:0] LAT_SAT = 42'd1048576125; // 125 * (2^23 + 1)
	localparam logic [30:0] LAT_REC125 = 31'd1099511628; // ceil(2^37/125)

	localparam logic [23:0] POS_MAX = 24'h7FFFFF;
	localparam logic [23:0] NEG_MAG_MAX = 24'h800000;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic ok;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} beat_t;
endpackage
`default_nettype wire

### sv/depth_pixel_backprojection_top.sv
// Depth pixel back-projection, top level. Uses dpb_pkg, dpb_lateral, dpb_depth_scale.
// One beat per cycle is accepted; busy is tied low.
// The depth is bounded by the lateral path: two multiplies, round/saturate, reciprocal /125.
// Results cannot be stalled; done is a one-cycle strobe.
// arst_n clears the valid pipeline and loads the default intrinsics.
`default_nettype none
module depth_pixel_backprojection_top #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write port
	input wire logic wr_en,
	input wire logic [1:0] wr_index,
	input wire logic [dpb_pkg::CFG_W-1:0] wr_data,
	// input beat
	input wire logic start,
	output logic busy,
	input wire logic [11:0] pixel_column,
	input wire logic [11:0] pixel_row,
	input wire logic [15:0] depth_mm,
	input wire logic [7:0] blue_in,
	input wire logic [7:0] green_in,
	input wire logic [7:0] red_in,
	// result beat
	output logic done,
	output logic point_valid,
	output logic signed [23:0] x_pos,
	output logic signed [23:0] y_pos,
	output logic [22:0] z_pos,
	output logic [7:0] blue_out,
	output logic [7:0] green_out,
	output logic [7:0] red_out,
	output logic [7:0] alpha_out
);
	// intrinsics; the user must write them only while the pipe is empty (not enforced here)
	logic [23:0] focal_x_inv_q, focal_y_inv_q;
	logic [15:0] center_x_q, center_y_q;

	// control/color beat that rides alongside the arithmetic
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	dpb_pkg::beat_t b_s1, b_s2, b_s3, b_s4, b_s5, b_s6;
	dpb_pkg::beat_t b_in;

	logic signed [23:0] x_raw, y_raw;
	logic [22:0] z_raw;
	logic accept;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_inv_q <= dpb_pkg::FOCAL_INV_RST;
			focal_y_inv_q <= dpb_pkg::FOCAL_INV_RST;
			center_x_q <= dpb_pkg::CENTER_X_RST;
			center_y_q <= dpb_pkg::CENTER_Y_RST;
		end else if (wr_en) begin
			unique case (dpb_pkg::cfg_reg_t'(wr_index))
				dpb_pkg::REG_FOCAL_X_INV: focal_x_inv_q <= wr_data[23:0];
				dpb_pkg::REG_FOCAL_Y_INV: focal_y_inv_q <= wr_data[23:0];
				dpb_pkg::REG_CENTER_X: center_x_q <= wr_data[15:0];
				dpb_pkg::REG_CENTER_Y: center_y_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// a point is good only with a depth reading and inside the frame
	always_comb begin
		b_in.ok = (depth_mm != 16'd0) && (32'(pixel_column) < MAX_COLUMNS) &&
			(32'(pixel_row) < MAX_ROWS);
		b_in.blue = blue_in;
		b_in.green = green_in;
		b_in.red = red_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		b_s1 <= b_in;
		b_s2 <= b_s1;
		b_s3 <= b_s2;
		b_s4 <= b_s3;
		b_s5 <= b_s4;
		b_s6 <= b_s5;
	end

	dpb_lateral u_lat_x (
		.clk(clk),
		.pix(pixel_column),
		.center(center_x_q),
		.finv(focal_x_inv_q),
		.depth(depth_mm),
		.pos(x_raw)
	);

	dpb_lateral u_lat_y (
		.clk(clk),
		.pix(pixel_row),
		.center(center_y_q),
		.finv(focal_y_inv_q),
		.depth(depth_mm),
		.pos(y_raw)
	);

	dpb_depth_scale u_depth (
		.clk(clk),
		.depth(depth_mm),
		.z(z_raw)
	);

	// bad points come out as all zero
	assign done = vld_s6;
	assign point_valid = b_s6.ok;
	assign x_pos = b_s6.ok ? x_raw : 24'sd0;
	assign y_pos = b_s6.ok ? y_raw : 24'sd0;
	assign z_pos = b_s6.ok ? z_raw : 23'd0;
	assign blue_out = b_s6.ok ? b_s6.blue : 8'd0;
	assign green_out = b_s6.ok ? b_s6.green : 8'd0;
	assign red_out = b_s6.ok ? b_s6.red : 8'd0;
	assign alpha_out = b_s6.ok ? dpb_pkg::ALPHA_OPAQUE : 8'd0;

`include "depth_pixel_backprojection_top_assert.svh"

	`DPB_ASSERT_DLY(a_latency, clk, arst_n, accept, 6, done)
	`DPB_ASSERT_IMP(a_bad_zero, clk, arst_n, done && !point_valid, x_pos == 24'sd0 && y_pos == 24'sd0 && z_pos == 23'd0 && alpha_out == 8'd0)
	`DPB_ASSERT_IMP(a_good_alpha, clk, arst_n, done && point_valid, alpha_out == dpb_pkg::ALPHA_OPAQUE && z_pos != 23'd0)
endmodule
`default_nettype wire

### sv/dpb_lateral.sv
// Six-stage lateral coordinate unit: (pix*16 - center) * finv * depth / 4096000.
// Depends on dpb_pkg.
`default_nettype none
module dpb_lateral (
	input wire logic clk,
	input wire logic [11:0] pix,
	input wire logic [15:0] center,
	input wire logic [23:0] finv,
	input wire logic [15:0] depth,
	output logic signed [23:0] pos
);
	logic [16:0] diff;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [15:0] mag_s1;
	logic [23:0] finv_s1;
	logic [15:0] depth_s1, depth_s2;
	logic [39:0] p1_s2;
	logic [55:0] p2_s3;
	logic [56:0] rnd;
	logic [41:0] q1;
	logic sat_s4, sat_s5;
	logic [29:0] q1_s4;
	logic [60:0] prod_s5;
	logic [23:0] q;
	logic [23:0] res;
	logic [23:0] pos_s6;

	assign diff = {1'b0, pix, 4'b0} - {1'b0, center};
	assign rnd = 57'(p2_s3) + dpb_pkg::LAT_HALF;
	assign q1 = rnd[56:15];
	assign q = prod_s5[60:37];

	always_comb begin
		if (neg_s5) begin
			res = (sat_s5 || q > dpb_pkg::NEG_MAG_MAX) ? dpb_pkg::NEG_MAG_MAX : (~q + 24'd1);
		end else begin
			res = (sat_s5 || q > dpb_pkg::POS_MAX) ? dpb_pkg::POS_MAX : q;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= diff[16];
		mag_s1 <= diff[16] ? 16'(-diff) : diff[15:0];
		finv_s1 <= finv;
		depth_s1 <= depth;

		p1_s2 <= 40'(mag_s1) * 40'(finv_s1);
		neg_s2 <= neg_s1;
		depth_s2 <= depth_s1;

		p2_s3 <= 56'(p1_s2) * 56'(depth_s2);
		neg_s3 <= neg_s2;

		q1_s4 <= q1[29:0];
		sat_s4 <= q1 >= dpb_pkg::LAT_SAT;
		neg_s4 <= neg_s3;

		prod_s5 <= 61'(q1_s4) * 61'(dpb_pkg::LAT_REC125);
		sat_s5 <= sat_s4;
		neg_s5 <= neg_s4;

		pos_s6 <= res;
	end

	assign pos = pos_s6;
endmodule
`default_nettype wire

### sv/dpb_depth_scale.sv
// Depth to Q7.16 metres, six stages to line up with the lateral units.
// Depends on dpb_pkg.
`default_nettype none
module dpb_depth_scale (
	input wire logic clk,
	input wire logic [15:0] depth,
	output logic [22:0] z
);
	logic [28:0] m_s1;
	logic [58:0] prod_s2;
	logic [22:0] z_s3, z_s4, z_s5, z_s6;

	always_ff @(posedge clk) begin
		m_s1 <= {depth, 13'b0} + dpb_pkg::Z_BIAS;
		prod_s2 <= 59'(m_s1) * 59'(dpb_pkg::Z_REC125);
		z_s3 <= prod_s2[58:36];
		z_s4 <= z_s3;
		z_s5 <= z_s4;
		z_s6 <= z_s5;
	end

	assign z = z_s6;
endmodule
`default_nettype wire
